>>> rtl/core/gda_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gda_pkg;

  // Fixed field widths of the request and response words
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned FIELD_W = 16;
  localparam int unsigned M400_W  = 9;

  // Request kinds
  localparam logic KIND_SET = 1'b0;
  localparam logic KIND_ADD = 1'b1;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;

  localparam int unsigned RESET_YEAR = 1900;
  localparam logic [M400_W-1:0] RESET_M400 = M400_W'(RESET_YEAR % 400);
  localparam logic [M400_W-1:0] M400_LAST  = 9'd399;
  localparam logic [M400_W:0]   CYCLE_400  = 10'd400;

  // Leap rule on the year taken modulo 400
  function automatic logic is_leap(input logic [M400_W-1:0] m400);
    logic century;
    century = (m400 == 9'd100) || (m400 == 9'd200) || (m400 == 9'd300);
    return (m400 == '0) || (!century && (m400[1:0] == 2'b00));
  endfunction

  // Days in a month; codes outside 1..12 read as 31
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/gda_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface gda_req_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [gda_pkg::DAY_W-1:0]     set_day;
  logic [gda_pkg::MONTH_W-1:0]   set_month;
  logic [gda_pkg::FIELD_W-1:0]   set_year;
  logic [gda_pkg::FIELD_W-1:0]   add_days;

  modport source (output valid, kind, set_day, set_month, set_year, add_days,
                  input ready);
  modport sink (input valid, kind, set_day, set_month, set_year, add_days,
                output ready);
endinterface

`default_nettype wire

>>> rtl/core/gda_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface gda_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [gda_pkg::DAY_W-1:0]     out_day;
  logic [gda_pkg::MONTH_W-1:0]   out_month;
  logic [gda_pkg::FIELD_W-1:0]   out_year;

  modport source (output valid, out_day, out_month, out_year, input ready);
  modport sink (input valid, out_day, out_month, out_year, output ready);
endinterface

`default_nettype wire

>>> rtl/core/gregorian_date_advance_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Sequencing: a set word passes through reciprocal multiply, mod-400 remainder,
//   validate/load and response load, in that order; an add word advances
//   one day per cycle until its count is spent, then loads the response.
// Throughput: one word at a time; req.ready returns the cycle after the response
//   is loaded. The day stepper sets the time an add word takes; the fixed two-step
//   mod-400 reduction of a loaded year sets the time a set word takes.
// Reset (rst, synchronous, active high): date 1/1/1900, sequencer idle, no response.
module gregorian_date_advance_top #(
  parameter int unsigned YEAR_BITS  = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  gda_req_if.sink   req,
  gda_rsp_if.source rsp
);
  import gda_pkg::*;

  // year / 400 = (year >> 4) / 25; the divide by 25 is a multiply by
  // ceil(2^(X_W+5) / 25), exact for every X_W-bit value.
  localparam int unsigned    X_W         = YEAR_BITS - 4;
  localparam int unsigned    RECIP_SHIFT = X_W + 5;
  localparam int unsigned    PROD_W      = 2 * X_W + 1;
  localparam longint unsigned RECIP_VAL  = ((64'd1 << RECIP_SHIFT) + 64'd24) / 64'd25;
  localparam logic [X_W:0]   RECIP       = (X_W + 1)'(RECIP_VAL);

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;  // quotient of year / 400
  localparam logic [2:0] ST_SETV = 3'd2;  // validate and load the date
  localparam logic [2:0] ST_ADD  = 3'd3;  // advance one day per cycle
  localparam logic [2:0] ST_DONE = 3'd4;  // hand date to the response register
  localparam logic [2:0] ST_REM  = 3'd5;  // year - 400 * quotient

  logic [2:0]            state;

  // Current date. cur_m400 tracks the year modulo 400 so the leap test
  // never needs a divider.
  logic [DAY_W-1:0]      cur_day;
  logic [MONTH_W-1:0]    cur_month;
  logic [YEAR_BITS-1:0]  cur_year;
  logic [M400_W-1:0]     cur_m400;
  logic [COUNT_BITS-1:0] days_left;

  // Pending set word
  logic [DAY_W-1:0]      pend_day;
  logic [MONTH_W-1:0]    pend_month;
  logic [YEAR_BITS-1:0]  pend_year;
  logic [M400_W-1:0]     q_lo;        // low bits of year / 400
  logic [M400_W-1:0]     rem;

  // Response register
  logic                  rsp_valid;
  logic [DAY_W-1:0]      rsp_day;
  logic [MONTH_W-1:0]    rsp_month;
  logic [FIELD_W-1:0]    rsp_year;

  logic accept;
  logic rsp_free;

  assign req.ready     = (state == ST_IDLE);
  assign accept        = req.valid && req.ready;
  assign rsp_free      = !rsp_valid || rsp.ready;
  assign rsp.valid     = rsp_valid;
  assign rsp.out_day   = rsp_day;
  assign rsp.out_month = rsp_month;
  assign rsp.out_year  = rsp_year;

  // Reciprocal product; only the low bits of the quotient matter, since the
  // remainder is below 400 and fits in M400_W bits
  logic [PROD_W-1:0] prod;
  assign prod = PROD_W'(pend_year[YEAR_BITS-1:4]) * PROD_W'(RECIP);

  // Set-word validation, with the reduced year
  logic               month_ok;
  logic [MONTH_W-1:0] set_month_v;
  logic [DAY_W-1:0]   set_len;
  logic               day_ok;
  assign month_ok    = (pend_month >= MONTH_JAN) && (pend_month <= MONTH_DEC);
  assign set_month_v = month_ok ? pend_month : MONTH_JAN;
  assign set_len     = month_len(set_month_v, is_leap(rem));
  assign day_ok      = (pend_day >= DAY_FIRST) && (pend_day <= set_len);

  // One-day step
  logic [DAY_W-1:0]     cur_len;
  logic                 month_end;
  logic                 year_end;
  logic [M400_W-1:0]    m400_inc;
  assign cur_len   = month_len(cur_month, is_leap(cur_m400));
  assign month_end = (cur_day >= cur_len);
  assign year_end  = (cur_month >= MONTH_DEC);
  // Year wraps to 0 past its top, and 0 is a multiple of 400
  assign m400_inc  = ((&cur_year) || (cur_m400 == M400_LAST)) ? '0 : cur_m400 + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cur_day   <= DAY_FIRST;
      cur_month <= MONTH_JAN;
      cur_year  <= YEAR_BITS'(RESET_YEAR);
      cur_m400  <= RESET_M400;
      days_left <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if ((state == ST_DONE) && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (req.kind == KIND_SET) begin
              state <= ST_MUL;
            end else begin
              days_left <= COUNT_BITS'(req.add_days);
              state     <= ST_ADD;
            end
          end
        end
        ST_MUL: begin
          state <= ST_REM;
        end
        ST_REM: begin
          state <= ST_SETV;
        end
        ST_SETV: begin
          cur_year  <= pend_year;
          cur_m400  <= rem;
          cur_month <= set_month_v;
          cur_day   <= day_ok ? pend_day : DAY_FIRST;
          days_left <= '0;
          state     <= ST_DONE;
        end
        ST_ADD: begin
          if (days_left == '0) begin
            state <= ST_DONE;
          end else begin
            days_left <= days_left - 1'b1;
            if (month_end) begin
              cur_day <= DAY_FIRST;
              if (year_end) begin
                cur_month <= MONTH_JAN;
                cur_year  <= cur_year + 1'b1;
                cur_m400  <= m400_inc;
              end else begin
                cur_month <= cur_month + 1'b1;
              end
            end else begin
              cur_day <= cur_day + 1'b1;
            end
          end
        end
        ST_DONE: begin
          if (rsp_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (accept && (req.kind == KIND_SET)) begin
      pend_day   <= req.set_day;
      pend_month <= req.set_month;
      pend_year  <= YEAR_BITS'(req.set_year);
    end
    if (state == ST_MUL) begin
      q_lo <= M400_W'(prod >> RECIP_SHIFT);
    end
    if (state == ST_REM) begin
      rem <= pend_year[M400_W-1:0] - M400_W'({1'b0, q_lo} * CYCLE_400);
    end
    if ((state == ST_DONE) && rsp_free) begin
      rsp_day   <= cur_day;
      rsp_month <= cur_month;
      rsp_year  <= FIELD_W'(cur_year);
    end
  end

  // Checks
  a_month_range: assert property (@(posedge clk) disable iff (rst)
    (cur_month >= MONTH_JAN) && (cur_month <= MONTH_DEC))
    else $error("month out of range");

  a_day_range: assert property (@(posedge clk) disable iff (rst)
    (cur_day >= DAY_FIRST) && (cur_day <= cur_len))
    else $error("day beyond month length");

  a_m400_range: assert property (@(posedge clk) disable iff (rst)
    cur_m400 <= M400_LAST)
    else $error("year residue out of range");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADD) && (days_left != '0) |=> days_left == $past(days_left) - 1'b1)
    else $error("day count did not step");

  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == ST_DONE)
    else $error("response raised outside completion");

endmodule

`default_nettype wire
